FILE: src/url_percent_codec_defines.svh
// Assertion macros shared by the URL percent codec RTL.
`ifndef URL_PERCENT_CODEC_DEFINES_SVH
`define URL_PERCENT_CODEC_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define UPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/upc_pkg.sv
// Types, character constants and helper functions of the URL percent codec.
package upc_pkg;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TILDE   = 8'h7E;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_LPAREN  = 8'h28;
    localparam logic [7:0] CHAR_RPAREN  = 8'h29;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;

    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_ENCODE_MODE        = 2'd0;
    localparam cfg_idx_t REG_SPACE_AS_PLUS      = 2'd1;
    localparam cfg_idx_t REG_ESCAPE_PUNCTUATION = 2'd2;

    // Uppercase hex digit for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] ext;
        ext = {4'b0000, n};
        return (n < 4'd10) ? (8'h30 + ext) : (8'h37 + ext);
    endfunction

    // Value of a hex digit; anything that is not a hex digit counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            v = c[3:0] + 4'd9;
        return v;
    endfunction

    function automatic logic [7:0] plain_decode(input logic [7:0] c);
        return (c == CHAR_PLUS) ? CHAR_SPACE : c;
    endfunction

    function automatic logic passes_through(input logic [7:0] c, input logic esc_punct);
        logic alnum;
        logic punct;
        alnum = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h30 && c <= 8'h39);
        punct = (c == CHAR_LPAREN) || (c == CHAR_RPAREN) ||
                (c == CHAR_COLON) || (c == CHAR_COMMA);
        return alnum || (c == CHAR_DASH) || (c == CHAR_UNDER) || (c == CHAR_DOT) ||
               (c == CHAR_TILDE) || (!esc_punct && punct);
    endfunction

endpackage

FILE: src/upc_ifs.sv
// Channel interfaces of the URL percent codec: input bytes, output bytes, register writes.
interface upc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface upc_cfg_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            index;
    logic                  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/url_percent_codec.sv
// URL percent encoder/decoder over a byte stream, with mode registers.
//
//  channel   dir  payload              notes
//  in_ch     in   in_byte, in_last     valid/ready, in_last ends the string
//  out_ch    out  out_byte, out_last   valid/ready, up to three beats per input beat
//  cfg_ch    in   index, data          valid/ready, always ready
//
// An input beat is converted in the cycle it is accepted and lands in a three-byte
// result register; its bytes leave one per cycle while out_ch is ready (three for an
// escaped byte in encode mode, one for a completed escape in decode mode).
// The next input beat is taken in the same cycle as the final result byte.
// rst_n restores the mode registers, clears the decoder phase and empties the result register (count and index only).
// A stalled out_ch holds the current byte and blocks further input beats.
module url_percent_codec (
    input  logic       clk,
    input  logic       rst_n,
    upc_in_if.sink     in_ch,
    upc_out_if.source  out_ch,
    upc_cfg_if.sink    cfg_ch
);
    import upc_pkg::*;
    `include "url_percent_codec_defines.svh"

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_NIB  = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] nibble_reg, nibble_next;
    logic       enc_reg, plus_reg, punct_reg;
    logic [7:0] bytes_reg [3];
    logic [7:0] bytes_next [3];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg;
    logic       last_reg;

    logic       in_fire, out_fire, final_beat;
    logic [7:0] c;

    assign c          = in_ch.in_byte;
    assign final_beat = (idx_reg == cnt_reg - 2'd1);
    assign out_fire   = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (cnt_reg == 2'd0) || (out_fire && final_beat);
    assign in_fire    = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid    = (cnt_reg != 2'd0);
    assign out_ch.out_byte = bytes_reg[idx_reg];
    assign out_ch.out_last = last_reg && final_beat;

    always_comb
    begin
        phase_next    = phase_reg;
        nibble_next   = nibble_reg;
        cnt_next      = 2'd0;
        bytes_next[0] = c;
        bytes_next[1] = 8'h00;
        bytes_next[2] = 8'h00;
        if (enc_reg)
        begin
            // Any byte taken in encode mode drops a pending escape.
            phase_next  = PH_IDLE;
            nibble_next = 4'd0;
            if (passes_through(c, punct_reg))
            begin
                cnt_next = 2'd1;
            end
            else if (plus_reg && c == CHAR_SPACE)
            begin
                cnt_next      = 2'd1;
                bytes_next[0] = CHAR_PLUS;
            end
            else
            begin
                cnt_next      = 2'd3;
                bytes_next[0] = CHAR_PERCENT;
                bytes_next[1] = hex_char(c[7:4]);
                bytes_next[2] = hex_char(c[3:0]);
            end
        end
        else
        begin
            case (phase_reg)
                PH_PCT:
                begin
                    if (in_ch.in_last)
                    begin
                        // The stream ended after a lone percent: replay it literally.
                        phase_next    = PH_IDLE;
                        cnt_next      = 2'd2;
                        bytes_next[0] = CHAR_PERCENT;
                        bytes_next[1] = plain_decode(c);
                    end
                    else
                    begin
                        nibble_next = hex_value(c);
                        phase_next  = PH_NIB;
                    end
                end
                PH_NIB:
                begin
                    phase_next    = PH_IDLE;
                    cnt_next      = 2'd1;
                    bytes_next[0] = {nibble_reg, hex_value(c)};
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (c == CHAR_PERCENT)
                    begin
                        if (in_ch.in_last)
                            cnt_next = 2'd1;
                        else
                            phase_next = PH_PCT;
                    end
                    else
                    begin
                        cnt_next      = 2'd1;
                        bytes_next[0] = plain_decode(c);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg    <= 1'b0;
            plus_reg   <= 1'b0;
            punct_reg  <= 1'b1;
            phase_reg  <= PH_IDLE;
            nibble_reg <= 4'd0;
            cnt_reg    <= 2'd0;
            idx_reg    <= 2'd0;
            last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                case (cfg_ch.index)
                    REG_ENCODE_MODE:        enc_reg   <= cfg_ch.data;
                    REG_SPACE_AS_PLUS:      plus_reg  <= cfg_ch.data;
                    REG_ESCAPE_PUNCTUATION: punct_reg <= cfg_ch.data;
                    default: ;
                endcase
            end
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                nibble_reg <= nibble_next;
                cnt_reg    <= cnt_next;
                idx_reg    <= 2'd0;
                last_reg   <= in_ch.in_last;
            end
            else if (out_fire)
            begin
                if (final_beat)
                begin
                    cnt_reg <= 2'd0;
                    idx_reg <= 2'd0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            bytes_reg[0] <= bytes_next[0];
            bytes_reg[1] <= bytes_next[1];
            bytes_reg[2] <= bytes_next[2];
        end
    end

    `UPC_ASSERT_NOW(a_idx_in_range, cnt_reg != 2'd0, idx_reg < cnt_reg,
                    "result index beyond the result count")
    `UPC_ASSERT_NOW(a_no_overwrite, in_fire && cnt_reg != 2'd0, out_fire && final_beat,
                    "input beat accepted over undelivered result bytes")
    `UPC_ASSERT_NEXT(a_escape_starts_pct, in_fire && enc_reg && cnt_next == 2'd3,
                     out_ch.valid && out_ch.out_byte == CHAR_PERCENT && !out_ch.out_last,
                     "encoded escape does not open with a percent")
    `UPC_ASSERT_NEXT(a_last_idles, in_fire && in_ch.in_last,
                     phase_reg == PH_IDLE && cnt_reg != 2'd0,
                     "last beat left the decoder busy or produced no output")

endmodule
